/* design/assert_macros.svh */
// Concurrent assertion helpers, clocked on clk_i and switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PTS_ASSERT_NEVER(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define PTS_ASSERT(name, prop, msg)
`define PTS_ASSERT_NEVER(name, prop, msg)
`endif
`endif

/* design/pts_pkg.sv */
package pts_pkg;

  localparam int MaxThreadsDef   = 16;
  localparam int PriorityBitsDef = 8;

  localparam int OpW      = 3;
  localparam int TidxW    = 4;
  localparam int PrioReqW = 8;
  localparam int TimeW    = 32;
  localparam int CurW     = 4;
  localparam int StatW    = 2;
  localparam int InDataW  = 80;
  localparam int OutDataW = 8;

  typedef enum logic [OpW-1:0] {
    OP_CREATE    = 3'd0,
    OP_BLOCK_CUR = 3'd1,
    OP_BLOCK_THR = 3'd2,
    OP_UNBLOCK   = 3'd3,
    OP_SLEEP_CUR = 3'd4,
    OP_SWITCH    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    TS_QUEUED   = 3'd0,
    TS_PAUSED   = 3'd1,
    TS_ACTIVE   = 3'd2,
    TS_WAITING  = 3'd3,
    TS_SLEEPING = 3'd4,
    TS_BLOCKED  = 3'd5
  } thr_state_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_IDX = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CREATE,
    CMD_BLOCK,
    CMD_UNBLOCK,
    CMD_SLEEP,
    CMD_WAKE,
    CMD_ACTIVATE
  } cmd_kind_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cmd_kind_e         kind;
    logic [TimeW-1:0]  sleep_ms;
    logic [TimeW-1:0]  now_ms;
  } cmd_t;

  // Control half of the selection word handed from cell to cell.
  typedef struct packed {
    logic       tok;
    logic       none;
    thr_state_e status;
  } scan_t;

endpackage

/* design/priority_thread_scheduler.sv */
// Channel   Direction  tdata / tuser
// s_axis    in         tuser: opcode; tdata: thread_index, priority_req, sleep_ms, now_ms
// m_axis    out        tdata: current_thread, switch_request, status
//
// Every operation but a context switch has its result word loaded into the output register
// on the accepting edge. A switch first wakes sleepers, then walks the selection down the
// row through each thread cell in turn, then commits the chosen thread.
// A new word is taken while the previous result is being accepted downstream.
// Reset clears the thread count and running index; the thread table itself is not cleared.
`include "assert_macros.svh"

module priority_thread_scheduler #(
  parameter int MAX_THREADS   = pts_pkg::MaxThreadsDef,
  parameter int PRIORITY_BITS = pts_pkg::PriorityBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [3:0] thread_index, [11:4] priority_req, [43:12] sleep_ms, [75:44] now_ms, rest zero
  input  logic [pts_pkg::InDataW-1:0]  s_axis_tdata,
  // [2:0] opcode
  input  logic [pts_pkg::OpW-1:0]      s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [3:0] current_thread, [4] switch_request, [6:5] status, [7] zero
  output logic [pts_pkg::OutDataW-1:0] m_axis_tdata
);
  import pts_pkg::*;

  localparam int IDX_W = $clog2(MAX_THREADS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam int CMP_W = (CNT_W > TidxW) ? CNT_W : TidxW;

  typedef enum logic {S_IDLE, S_SCAN} state_e;

  state_e                state_q;
  logic                  start_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      run_q;
  logic                  m_valid_q;
  logic [OutDataW-1:0]   m_data_q;

  logic [TidxW-1:0]         in_tidx;
  logic [PrioReqW-1:0]      in_prio;
  logic [TimeW-1:0]         in_sleep;
  logic [TimeW-1:0]         in_now;
  logic [PRIORITY_BITS-1:0] prio_ext;
  logic                     s_fire;
  logic                     idx_ok;
  logic                     have_cur;
  logic                     scan_done;
  logic                     go_scan;
  logic                     req;
  status_e                  stat;
  logic [IDX_W-1:0]         pick_idx;

  cmd_t                     cmd;
  logic [IDX_W-1:0]         cmd_idx;

  scan_t                    scan_w     [MAX_THREADS+1];
  logic [IDX_W-1:0]         sel_idx_w  [MAX_THREADS+1];
  logic [PRIORITY_BITS-1:0] sel_prio_w [MAX_THREADS+1];
  logic [MAX_THREADS:0]     tok_vec;

  assign in_tidx  = s_axis_tdata[3:0];
  assign in_prio  = s_axis_tdata[11:4];
  assign in_sleep = s_axis_tdata[43:12];
  assign in_now   = s_axis_tdata[75:44];
  assign prio_ext = PRIORITY_BITS'(in_prio);

  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign idx_ok        = CMP_W'(in_tidx) < CMP_W'(count_q);
  assign have_cur      = (count_q != '0) && (CNT_W'(run_q) < count_q);
  assign scan_done     = scan_w[MAX_THREADS].tok;
  assign pick_idx      = sel_idx_w[MAX_THREADS];

  always_comb begin
    cmd.kind     = CMD_NONE;
    cmd.sleep_ms = in_sleep;
    cmd.now_ms   = in_now;
    cmd_idx      = run_q;
    count_d      = count_q;
    req          = 1'b0;
    stat         = STAT_OK;
    go_scan      = 1'b0;
    if (s_fire) begin
      unique case (op_e'(s_axis_tuser))
        OP_CREATE: begin
          if (count_q < CNT_W'(MAX_THREADS)) begin
            cmd.kind = CMD_CREATE;
            cmd_idx  = IDX_W'(count_q);
            count_d  = count_q + CNT_W'(1);
          end else begin
            stat = STAT_FULL;
          end
        end
        OP_BLOCK_CUR: begin
          if (have_cur) begin
            cmd.kind = CMD_BLOCK;
            req      = 1'b1;
          end else begin
            stat = STAT_BAD_IDX;
          end
        end
        OP_BLOCK_THR: begin
          if (idx_ok) begin
            cmd.kind = CMD_BLOCK;
            cmd_idx  = IDX_W'(in_tidx);
          end else begin
            stat = STAT_BAD_IDX;
          end
        end
        OP_UNBLOCK: begin
          if (idx_ok) begin
            cmd.kind = CMD_UNBLOCK;
            cmd_idx  = IDX_W'(in_tidx);
            req      = 1'b1;
          end else begin
            stat = STAT_BAD_IDX;
          end
        end
        OP_SLEEP_CUR: begin
          if (have_cur) begin
            cmd.kind = CMD_SLEEP;
            req      = 1'b1;
          end else begin
            stat = STAT_BAD_IDX;
          end
        end
        OP_SWITCH: begin
          if (count_q != '0) begin
            cmd.kind = CMD_WAKE;
            go_scan  = 1'b1;
          end else begin
            stat = STAT_BAD_IDX;
          end
        end
        default: ;
      endcase
    end else if (state_q == S_SCAN && scan_done) begin
      cmd.kind = CMD_ACTIVATE;
      cmd_idx  = sel_idx_w[MAX_THREADS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      start_q   <= 1'b0;
      count_q   <= '0;
      run_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      start_q <= go_scan;
      unique case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            count_q   <= count_d;
            m_valid_q <= !go_scan;
            if (go_scan) begin
              state_q <= S_SCAN;
            end else begin
              m_data_q <= {1'b0, stat, req, CurW'(run_q)};
            end
          end else if (m_axis_tready) begin
            m_valid_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state_q   <= S_IDLE;
            run_q     <= sel_idx_w[MAX_THREADS];
            m_valid_q <= 1'b1;
            m_data_q  <= {1'b0, STAT_OK, 1'b0, CurW'(sel_idx_w[MAX_THREADS])};
          end else if (m_axis_tready) begin
            m_valid_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The selection word enters the first cell in the cycle after the wake-up pass.
  assign scan_w[0].tok    = start_q;
  assign scan_w[0].none   = 1'b1;
  assign scan_w[0].status = TS_QUEUED;
  assign sel_idx_w[0]     = '0;
  assign sel_prio_w[0]    = '0;
  assign tok_vec[0]       = start_q;

  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
    logic used;
    assign used = CNT_W'(i) < count_q;

    pts_cell #(
      .CELL_IDX (i),
      .IDX_W    (IDX_W),
      .PRIO_W   (PRIORITY_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .cmd_idx_i  (cmd_idx),
      .cmd_prio_i (prio_ext),
      .used_i     (used),
      .scan_i     (scan_w[i]),
      .sel_idx_i  (sel_idx_w[i]),
      .sel_prio_i (sel_prio_w[i]),
      .scan_o     (scan_w[i+1]),
      .sel_idx_o  (sel_idx_w[i+1]),
      .sel_prio_o (sel_prio_w[i+1])
    );

    assign tok_vec[i+1] = scan_w[i+1].tok;
  end

  `PTS_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_THREADS), "thread count too high")
  `PTS_ASSERT(a_single_token, $onehot0(tok_vec), "several selection words in row")
  `PTS_ASSERT_NEVER(a_scan_out_busy, state_q == S_SCAN && m_valid_q, "result during scan")
  `PTS_ASSERT(a_pick_in_table, scan_done |-> (CNT_W'(pick_idx) < count_q), "pick off table")
  `PTS_ASSERT(a_run_in_table, (count_q != '0) |-> (CNT_W'(run_q) < count_q), "run off table")

endmodule

/* design/pts_cell.sv */
module pts_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 4,
  parameter int PRIO_W   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts_pkg::cmd_t     cmd_i,
  input  logic [IDX_W-1:0]  cmd_idx_i,
  input  logic [PRIO_W-1:0] cmd_prio_i,
  input  logic              used_i,
  input  pts_pkg::scan_t    scan_i,
  input  logic [IDX_W-1:0]  sel_idx_i,
  input  logic [PRIO_W-1:0] sel_prio_i,
  output pts_pkg::scan_t    scan_o,
  output logic [IDX_W-1:0]  sel_idx_o,
  output logic [PRIO_W-1:0] sel_prio_o
);
  import pts_pkg::*;

  thr_state_e        st_q, st_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [TimeW-1:0]  delay_q, delay_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic [TimeW-1:0]  elapsed;
  logic              hit;
  logic              eligible;
  logic              take;
  logic              tok_q;
  logic              none_q;
  thr_state_e        sel_st_q;
  logic [IDX_W-1:0]  sel_idx_q;
  logic [PRIO_W-1:0] sel_prio_q;

  assign hit     = (cmd_idx_i == IDX_W'(CELL_IDX));
  assign elapsed = cmd_i.now_ms - start_q;

  always_comb begin
    st_d    = st_q;
    prio_d  = prio_q;
    delay_d = delay_q;
    start_d = start_q;
    unique case (cmd_i.kind)
      CMD_CREATE: begin
        if (hit) begin
          st_d   = TS_QUEUED;
          prio_d = cmd_prio_i;
        end
      end
      CMD_BLOCK: begin
        if (hit) st_d = TS_BLOCKED;
      end
      CMD_UNBLOCK: begin
        if (hit) st_d = TS_PAUSED;
      end
      CMD_SLEEP: begin
        if (hit) begin
          st_d    = TS_SLEEPING;
          delay_d = cmd_i.sleep_ms;
          start_d = cmd_i.now_ms;
        end
      end
      CMD_WAKE: begin
        // A sleeper whose time has run out and the running thread both end up paused.
        if (used_i) begin
          if (st_q == TS_SLEEPING && elapsed >= delay_q) begin
            st_d = TS_PAUSED;
          end else if (hit && st_q == TS_ACTIVE) begin
            st_d = TS_PAUSED;
          end
        end
      end
      CMD_ACTIVATE: begin
        if (hit) st_d = TS_ACTIVE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    prio_q  <= prio_d;
    delay_q <= delay_d;
    start_q <= start_d;
  end

  // The first cell takes the choice unconditionally; later ones only if more urgent,
  // or equally urgent and paused against a queued choice.
  assign eligible = used_i && (st_q < TS_WAITING);
  assign take     = scan_i.none ||
                    (eligible && ((prio_q < sel_prio_i) ||
                                  (prio_q == sel_prio_i && st_q == TS_PAUSED &&
                                   scan_i.status == TS_QUEUED)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= scan_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_i.tok) begin
      none_q <= 1'b0;
      if (take) begin
        sel_st_q   <= st_q;
        sel_idx_q  <= IDX_W'(CELL_IDX);
        sel_prio_q <= prio_q;
      end else begin
        sel_st_q   <= scan_i.status;
        sel_idx_q  <= sel_idx_i;
        sel_prio_q <= sel_prio_i;
      end
    end
  end

  assign scan_o.tok    = tok_q;
  assign scan_o.none   = none_q;
  assign scan_o.status = sel_st_q;
  assign sel_idx_o     = sel_idx_q;
  assign sel_prio_o    = sel_prio_q;

endmodule
